// ----- rtl/keypad_press_qualifier_macros.svh -----
// ----------------------------------------------------------------------------
// keypad_press_qualifier_macros.svh
// Assertion helpers shared by the key qualifier RTL.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_PRESS_QUALIFIER_MACROS_SVH
`define KEYPAD_PRESS_QUALIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define KPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/kpq_pkg.sv -----
// ----------------------------------------------------------------------------
// kpq_pkg
// Shared types, constants and helpers of the key press qualifier.
// ----------------------------------------------------------------------------
package kpq_pkg;

  localparam int TICK_W    = 16;                   // internal tick arithmetic width
  localparam int NOW_W     = 16;                   // now_tick field width
  localparam int CFG_W     = 16;                   // register width
  localparam int CMP_W     = (TICK_W > CFG_W) ? TICK_W : CFG_W;
  localparam int NIB_CNT   = (TICK_W + 3) / 4;
  localparam int PAD_W     = NIB_CNT * 4;
  localparam int KEY_CNT   = 6;
  localparam int LEVEL_W   = 7;
  localparam int LEARN_BIT = 6;
  localparam int EVENT_W   = 4;
  localparam int IDX_W     = 2;

  localparam logic [EVENT_W-1:0] EV_NONE       = 4'd0;
  localparam logic [EVENT_W-1:0] EV_SET_L      = 4'd1;
  localparam logic [EVENT_W-1:0] EV_SET_L_LONG = 4'd2;
  localparam logic [EVENT_W-1:0] EV_UP_R       = 4'd3;
  localparam logic [EVENT_W-1:0] EV_DOWN_R     = 4'd4;
  localparam logic [EVENT_W-1:0] EV_SET_R      = 4'd5;
  localparam logic [EVENT_W-1:0] EV_UP_L       = 4'd6;
  localparam logic [EVENT_W-1:0] EV_DOWN_L     = 4'd7;
  localparam logic [EVENT_W-1:0] EV_LEARN      = 4'd8;

  typedef enum logic [IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_REPEAT   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_SECOND  = 2'd2,
    PH_REPEAT  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SET_LONG,
    KIND_SET,
    KIND_UPDOWN
  } key_kind_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] long_press;
    logic [CFG_W-1:0] repeat_delay;
  } cfg_t;

  typedef struct packed {
    logic fire;       // key gives an event on this poll
    logic long_evt;   // the event is the long-press one
    logic repeating;  // key sits in auto-repeat after this poll
  } key_stat_t;

  function automatic key_kind_t key_kind(input int k);
    key_kind_t kd;
    if (k == 0) kd = KIND_SET_LONG;
    else if (k == 3) kd = KIND_SET;
    else kd = KIND_UPDOWN;
    return kd;
  endfunction

  function automatic logic [EVENT_W-1:0] key_code(input int k);
    logic [EVENT_W-1:0] c;
    unique case (k)
      0:       c = EV_SET_L;
      1:       c = EV_UP_R;
      2:       c = EV_DOWN_R;
      3:       c = EV_SET_R;
      4:       c = EV_UP_L;
      5:       c = EV_DOWN_L;
      default: c = EV_NONE;
    endcase
    return c;
  endfunction

  // 16 == 1 mod 5, so the nibble sum keeps the residue; fold twice, then
  // match the three values below 16 that leave 4.
  function automatic logic rep_hit(input logic [TICK_W-1:0] el);
    logic [PAD_W-1:0] p;
    logic [6:0]       s1;
    logic [4:0]       s2;
    logic [4:0]       s3;
    p  = PAD_W'(el);
    s1 = '0;
    for (int i = 0; i < NIB_CNT; i++) begin
      s1 = s1 + 7'(p[4*i +: 4]);
    end
    s2 = 5'(s1[6:4]) + 5'(s1[3:0]);
    s3 = 5'(s2[4]) + 5'(s2[3:0]);
    return (s3 == 5'd4) || (s3 == 5'd9) || (s3 == 5'd14);
  endfunction

endpackage

// ----- rtl/kpq_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// kpq_cfg_regs
// Threshold registers written through the configuration channel.
// ----------------------------------------------------------------------------
module kpq_cfg_regs
  import kpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg_nxt.debounce     = cfg_data;
        REG_LONG:     cfg_nxt.long_press   = cfg_data;
        REG_REPEAT:   cfg_nxt.repeat_delay = cfg_data;
        default:      cfg_nxt = cfg_r;  // unmapped index: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce     <= CFG_W'(20);
      cfg_r.long_press   <= CFG_W'(800);
      cfg_r.repeat_delay <= CFG_W'(400);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/kpq_key.sv -----
// ----------------------------------------------------------------------------
// kpq_key
// One key's held flag, press start tick and phase machine.
// ----------------------------------------------------------------------------
module kpq_key
  import kpq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  key_kind_t         kind,
  input  cfg_t              cfg,
  input  logic              low,
  input  logic [TICK_W-1:0] now,
  input  logic              commit,
  output key_stat_t         stat
);

  logic              held_r, held_nxt;
  logic [TICK_W-1:0] start_r, start_nxt;
  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] el;
  logic              gt_deb, gt_long, gt_rep;

  assign el      = now - start_r;
  assign gt_deb  = CMP_W'(el) > CMP_W'(cfg.debounce);
  assign gt_long = CMP_W'(el) > CMP_W'(cfg.long_press);
  assign gt_rep  = CMP_W'(el) > CMP_W'(cfg.repeat_delay);

  always_comb begin
    held_nxt      = held_r;
    start_nxt     = start_r;
    phase_nxt     = phase_r;
    stat.fire     = 1'b0;
    stat.long_evt = 1'b0;
    if (!low) begin
      held_nxt  = 1'b0;
      start_nxt = '0;
      phase_nxt = PH_IDLE;
    end else if (!held_r) begin
      held_nxt  = 1'b1;
      start_nxt = now;
      phase_nxt = PH_IDLE;
    end else begin
      unique case (kind)
        KIND_SET_LONG: begin
          if (gt_long && phase_r == PH_PRESSED) begin
            phase_nxt     = PH_SECOND;
            stat.fire     = 1'b1;
            stat.long_evt = 1'b1;
          end else if (gt_deb && phase_r == PH_IDLE) begin
            phase_nxt = PH_PRESSED;
            stat.fire = 1'b1;
          end
        end
        KIND_SET: begin
          if (gt_deb && phase_r == PH_IDLE) begin
            phase_nxt = PH_PRESSED;
            stat.fire = 1'b1;
          end
        end
        KIND_UPDOWN: begin
          if (gt_rep) begin
            if (phase_r == PH_PRESSED) begin
              phase_nxt = PH_SECOND;
              stat.fire = 1'b1;
            end else if (phase_r == PH_SECOND || phase_r == PH_REPEAT) begin
              phase_nxt = PH_REPEAT;
              stat.fire = rep_hit(el);
            end
          end else if (gt_deb && phase_r == PH_IDLE) begin
            phase_nxt = PH_PRESSED;
            stat.fire = 1'b1;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
    stat.repeating = commit ? (phase_nxt == PH_REPEAT) : (phase_r == PH_REPEAT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      start_r <= '0;
      phase_r <= PH_IDLE;
    end else if (commit) begin
      held_r  <= held_nxt;
      start_r <= start_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ----- rtl/kpq_scan.sv -----
// ----------------------------------------------------------------------------
// kpq_scan
// Six key machines behind a priority chain, plus the learn key.
// ----------------------------------------------------------------------------
module kpq_scan
  import kpq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               step,
  input  logic [LEVEL_W-1:0] levels,
  input  logic [NOW_W-1:0]   now_tick,
  output logic [EVENT_W-1:0] key_event,
  output logic               quiet_repeat
);

  key_stat_t         stat [KEY_CNT];
  logic [KEY_CNT:0]  reach;
  logic [KEY_CNT-1:0] rep_vec;
  logic [TICK_W-1:0] now_t;

  assign now_t    = TICK_W'(now_tick);
  assign reach[0] = 1'b1;

  for (genvar k = 0; k < KEY_CNT; k++) begin : g_key
    assign reach[k+1] = reach[k] & ~stat[k].fire;
    assign rep_vec[k] = stat[k].repeating;

    kpq_key u_key (
      .clk    (clk),
      .rst_n  (rst_n),
      .kind   (key_kind(k)),
      .cfg    (cfg),
      .low    (~levels[k]),
      .now    (now_t),
      .commit (step & reach[k]),
      .stat   (stat[k])
    );
  end

  assign quiet_repeat = |rep_vec;

  // Only one reached key can fire: it is the one that cuts the chain.
  always_comb begin
    key_event = EV_NONE;
    for (int k = 0; k < KEY_CNT; k++) begin
      if (reach[k] && stat[k].fire) begin
        key_event = stat[k].long_evt ? EV_SET_L_LONG : key_code(k);
      end
    end
    if (reach[KEY_CNT] && !levels[LEARN_BIT]) begin
      key_event = EV_LEARN;
    end
  end

endmodule

// ----- rtl/keypad_press_qualifier.sv -----
// ----------------------------------------------------------------------------
// keypad_press_qualifier
// Key debounce, long-press and auto-repeat qualifier for a polled keypad.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload
//  --------+-----------+---------------------------------------------------
//  in_     | sink      | key_levels[6:0], now_tick[22:7] (one poll per beat)
//  out_    | source    | key_event[3:0], quiet_repeat[4] (one result a poll)
//  cfg_    | sink      | cfg_index selects debounce/long/repeat, cfg_data
//
//  One poll per cycle sustained while out_tready stays high; a result
//  passes the input register, then the result register. Key state updates
//  when a poll moves from the input register into the result register.
//  Reset (rst_n low, synchronous) clears all key state, restores thresholds
//  20/800/400 and empties both registers.
//  A stalled out_ side holds the result; in_tready then drops once the input
//  register is also full. cfg_ready is always high.
//
module keypad_press_qualifier
  import kpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // poll input
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,   // [6:0] key_levels, [22:7] now_tick, [23] zero
  // result output
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [3:0] key_event, [4] quiet_repeat, [7:5] zero
  // register writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  `include "keypad_press_qualifier_macros.svh"

  cfg_t               cfg;

  // input register
  logic               s1_vld_r, s1_vld_nxt;
  logic [LEVEL_W-1:0] s1_levels_r;
  logic [NOW_W-1:0]   s1_now_r;

  // result register
  logic               out_vld_r, out_vld_nxt;
  logic [EVENT_W-1:0] out_event_r;
  logic               out_quiet_r;

  logic               adv;       // result register can take a poll
  logic               step;      // poll commits this cycle
  logic               in_beat;
  logic [EVENT_W-1:0] scan_event;
  logic               scan_quiet;

  assign adv       = !out_vld_r || out_tready;
  assign step      = s1_vld_r && adv;
  assign in_tready = !s1_vld_r || adv;
  assign in_beat   = in_tvalid && in_tready;

  kpq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kpq_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .step         (step),
    .levels       (s1_levels_r),
    .now_tick     (s1_now_r),
    .key_event    (scan_event),
    .quiet_repeat (scan_quiet)
  );

  // Hold the input beat until it commits; refill on the same edge.
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_beat) begin
      s1_vld_nxt = 1'b1;
    end else if (step) begin
      s1_vld_nxt = 1'b0;
    end
  end

  // Load a result on commit; drop valid once taken.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (step) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_levels_r <= in_tdata[LEVEL_W-1:0];
      s1_now_r    <= in_tdata[LEVEL_W +: NOW_W];
    end
    if (step) begin
      out_event_r <= scan_event;
      out_quiet_r <= scan_quiet;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_quiet_r, out_event_r};

  `KPQ_ASSERT_NEXT(a_commit_lands, step, out_vld_r, "committed poll did not reach the result register")
  `KPQ_ASSERT_NOW(a_blocked_no_accept, s1_vld_r && !adv, !in_tready, "beat accepted over a held poll")
  `KPQ_ASSERT_NOW(a_event_range, out_vld_r, out_event_r <= EV_LEARN, "key_event out of range")
  `KPQ_ASSERT_NEXT(a_stall_keeps_poll, s1_vld_r && !adv, s1_vld_r && $stable(s1_now_r), "held poll lost while stalled")

endmodule

// ----- sim/keypad_press_qualifier_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_press_qualifier_test
// Self-checking bench for the keypad press qualifier. A directed table covers
// reset, debounce, long press, repeat across tick wrap, priority masking and
// the learn key. Randomized press sequences then run under several threshold
// settings. Each result beat is scored against its typed row or the key model.
// ----------------------------------------------------------------------------
module keypad_press_qualifier_test;
  import kpq_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int STALL_CYCLES  = 48;    // long receiver hold-off
  localparam int WATCHDOG_MAX  = 1000;  // cycles with no beat on any channel
  localparam int REPEAT_MOD    = 5;
  localparam int REPEAT_RES    = 4;
  localparam int DIRECTED_ROWS = 25;

  // One result of a poll: what the scoreboard waits for.
  typedef struct packed {
    logic [EVENT_W-1:0] ev;
    logic               quiet;
  } poll_result_t;

  // One row of the directed table. Rows with typed set carry their result;
  // the rest are scored against the key model.
  typedef struct packed {
    logic [LEVEL_W-1:0] levels;
    logic [NOW_W-1:0]   tick;
    logic               typed;
    logic [EVENT_W-1:0] ev;
    logic               quiet;
  } poll_row_t;

  // Directed table, run with the reset thresholds 20 / 800 / 400.
  localparam poll_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{7'h7F, 16'h0000, 1'b1, EV_NONE,       1'b0},  // nothing pressed after reset
    '{7'h7F, 16'hFFFF, 1'b1, EV_NONE,       1'b0},  // top tick
    '{7'h3F, 16'h0005, 1'b1, EV_LEARN,      1'b0},  // learn low alone
    '{7'h7E, 16'h0000, 1'b1, EV_NONE,       1'b0},  // left set down at tick zero
    '{7'h7E, 16'h0014, 1'b1, EV_NONE,       1'b0},  // elapsed equals debounce
    '{7'h7E, 16'h0015, 1'b1, EV_SET_L,      1'b0},  // one past debounce
    '{7'h7E, 16'h0335, 1'b1, EV_SET_L_LONG, 1'b0},  // past long press
    '{7'h7E, 16'h07D0, 1'b1, EV_NONE,       1'b0},  // silent after long event
    '{7'h7F, 16'h07D1, 1'b1, EV_NONE,       1'b0},  // release
    '{7'h7D, 16'hFFF0, 1'b1, EV_NONE,       1'b0},  // right up down near wrap
    '{7'h7D, 16'h0005, 1'b1, EV_UP_R,       1'b0},  // debounce across wrap
    '{7'h7D, 16'h0181, 1'b1, EV_UP_R,       1'b0},  // past repeat delay
    '{7'h7D, 16'h0184, 1'b1, EV_UP_R,       1'b1},  // elapsed mod 5 hits 4
    '{7'h7D, 16'h0185, 1'b1, EV_NONE,       1'b1},  // repeating, off residue
    '{7'h3D, 16'h0186, 1'b1, EV_LEARN,      1'b1},  // learn behind a quiet key
    '{7'h00, 16'h0200, 1'b0, EV_NONE,       1'b0},  // everything low
    '{7'h00, 16'h0220, 1'b0, EV_NONE,       1'b0},  // left set masks the rest
    '{7'h00, 16'h0221, 1'b0, EV_NONE,       1'b0},
    '{7'h00, 16'h0222, 1'b0, EV_NONE,       1'b0},
    '{7'h00, 16'h0223, 1'b0, EV_NONE,       1'b0},
    '{7'h00, 16'h0225, 1'b0, EV_NONE,       1'b0},
    '{7'h7F, 16'h0300, 1'b1, EV_NONE,       1'b0},  // release all
    '{7'h7B, 16'h1000, 1'b1, EV_NONE,       1'b0},  // right down down
    '{7'h7B, 16'h11F4, 1'b1, EV_NONE,       1'b0},  // past repeat still in idle
    '{7'h7F, 16'h11F5, 1'b1, EV_NONE,       1'b0}
  };

  localparam logic [EVENT_W-1:0] KEY_EVENT [KEY_CNT] = '{
    EV_SET_L, EV_UP_R, EV_DOWN_R, EV_SET_R, EV_UP_L, EV_DOWN_L
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;   // [6:0] key_levels, [22:7] now_tick, [23] zero
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // [3:0] key_event, [4] quiet_repeat, [7:5] zero
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Key model state and its copy of the thresholds.
  logic                 key_down    [KEY_CNT];
  logic [TICK_W-1:0]    press_tick  [KEY_CNT];
  phase_t               press_stage [KEY_CNT];
  logic [CFG_W-1:0]     debounce_thr;
  logic [CFG_W-1:0]     long_thr;
  logic [CFG_W-1:0]     repeat_thr;

  poll_result_t         pending_results [$];
  int                   mismatches;
  int                   idle_cycles;

  // Random press pattern carried from beat to beat.
  logic [KEY_CNT-1:0]   held_keys;
  logic [NOW_W-1:0]     sweep_tick;

  bit                   src_gaps_on;
  bit                   sink_gaps_on;
  bit                   stall_request;

  keypad_press_qualifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Key model: scan the six keys in priority order, stop at the first event,
  // fall through to the learn key.
  // --------------------------------------------------------------------------
  function automatic poll_result_t qualify_poll(input logic [LEVEL_W-1:0] lv,
                                                input logic [NOW_W-1:0]   tk);
    poll_result_t      res;
    logic [TICK_W-1:0] el;
    bit                done;
    int                k;
    res  = '0;
    done = 1'b0;
    for (k = 0; k < KEY_CNT; k++) begin
      if (!done) begin
        if (lv[k]) begin
          // key up: forget the press
          key_down[k]    = 1'b0;
          press_tick[k]  = '0;
          press_stage[k] = PH_IDLE;
        end else if (!key_down[k]) begin
          // first low poll: stamp the press, no event yet
          key_down[k]    = 1'b1;
          press_tick[k]  = tk;
          press_stage[k] = PH_IDLE;
        end else begin
          el = tk - press_tick[k];
          if (k == 0) begin
            if (el > long_thr && press_stage[0] == PH_PRESSED) begin
              press_stage[0] = PH_SECOND;
              res.ev = EV_SET_L_LONG;
              done   = 1'b1;
            end else if (el > debounce_thr && press_stage[0] == PH_IDLE) begin
              press_stage[0] = PH_PRESSED;
              res.ev = EV_SET_L;
              done   = 1'b1;
            end
          end else if (k == 3) begin
            if (el > debounce_thr && press_stage[3] == PH_IDLE) begin
              press_stage[3] = PH_PRESSED;
              res.ev = EV_SET_R;
              done   = 1'b1;
            end
          end else if (el > repeat_thr) begin
            // up/down past the repeat delay; a key still idle stays silent
            if (press_stage[k] == PH_PRESSED) begin
              press_stage[k] = PH_SECOND;
              done = 1'b1;
            end else if (press_stage[k] != PH_IDLE) begin
              press_stage[k] = PH_REPEAT;
              done = ((el % REPEAT_MOD) == REPEAT_RES);
            end
            if (done) res.ev = KEY_EVENT[k];
          end else if (el > debounce_thr && press_stage[k] == PH_IDLE) begin
            press_stage[k] = PH_PRESSED;
            res.ev = KEY_EVENT[k];
            done   = 1'b1;
          end
        end
      end
    end
    if (!done && !lv[LEARN_BIT]) res.ev = EV_LEARN;
    res.quiet = (press_stage[1] == PH_REPEAT) || (press_stage[2] == PH_REPEAT) ||
                (press_stage[4] == PH_REPEAT) || (press_stage[5] == PH_REPEAT);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Offer one poll beat, hold it until accepted, then log what it must give.
  // in_tvalid stays high after the beat so back-to-back polls need no bubble.
  // --------------------------------------------------------------------------
  task automatic send_poll(input logic [LEVEL_W-1:0] lv, input logic [NOW_W-1:0] tk,
                           input logic typed, input poll_result_t typed_res);
    poll_result_t predicted;
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, tk, lv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = qualify_poll(lv, tk);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid, drain every pending result, let the pipe settle, then write
  // all three thresholds back to back.
  task automatic load_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                                 input logic [CFG_W-1:0] rpt);
    reg_idx_t         idx;
    logic [CFG_W-1:0] val;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int r = 0; r < 3; r++) begin
      idx = reg_idx_t'(r);
      case (idx)
        REG_DEBOUNCE: val = deb;
        REG_LONG:     val = lng;
        default:      val = rpt;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        REG_DEBOUNCE: debounce_thr = val;
        REG_LONG:     long_thr     = val;
        default:      repeat_thr   = val;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Random polls: mostly keys pressed and held for a while as time advances
  // in small steps, now and then a tick jump or a beat of pure noise.
  task automatic run_random(input int count, input int step_max);
    logic [LEVEL_W-1:0] lv;
    logic               learn_low;
    int                 i;
    int                 k;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        lv         = LEVEL_W'($urandom);
        sweep_tick = NOW_W'($urandom);
      end else begin
        for (k = 0; k < KEY_CNT; k++) begin
          if (held_keys[k]) held_keys[k] = ($urandom_range(0, 17) != 0);
          else held_keys[k] = ($urandom_range(0, 9) == 0);
        end
        if ($urandom_range(0, 39) == 0) sweep_tick = NOW_W'($urandom);
        else sweep_tick = sweep_tick + NOW_W'($urandom_range(0, step_max));
        learn_low = ($urandom_range(0, 4) == 0);
        lv = {~learn_low, ~held_keys};
      end
      send_poll(lv, sweep_tick, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, then randomized phases with new
  // thresholds loaded between them.
  // --------------------------------------------------------------------------
  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    mismatches   = 0;
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    stall_request = 1'b0;
    held_keys    = '0;
    sweep_tick   = '0;
    debounce_thr = 16'd20;
    long_thr     = 16'd800;
    repeat_thr   = 16'd400;
    for (int k = 0; k < KEY_CNT; k++) begin
      key_down[k]    = 1'b0;
      press_tick[k]  = '0;
      press_stage[k] = PH_IDLE;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_poll(DIRECTED[r].levels, DIRECTED[r].tick, DIRECTED[r].typed,
                poll_result_t'{DIRECTED[r].ev, DIRECTED[r].quiet});
    end

    // short thresholds so presses reach repeat and long press quickly
    load_thresholds(16'd3, 16'd30, 16'd12);
    stall_request = 1'b1;
    run_random(350, 3);
    // zero thresholds: events once the tick moves on from the press tick
    load_thresholds(16'd0, 16'd0, 16'd0);
    run_random(200, 3);
    // top thresholds: only the learn key can report
    load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(100, 3);
    // debounce above repeat delay: up/down keys go silent
    load_thresholds(16'd15, 16'd8, 16'd6);
    run_random(250, 3);
    load_thresholds(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(10, 60)),
                    CFG_W'($urandom_range(5, 30)));
    stall_request = 1'b1;
    run_random(250, 3);
    // reset thresholds with coarse tick steps
    load_thresholds(16'd20, 16'd800, 16'd400);
    run_random(300, 80);
    // final stretch at full rate on both sides
    load_thresholds(16'd2, 16'd20, 16'd9);
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    run_random(350, 3);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready bursts, plus a long hold-off on request so the
  // result and input registers fill and in_tready drops.
  // --------------------------------------------------------------------------
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (sink_gaps_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Score every result beat against the oldest pending poll.
  always @(posedge clk) begin : score_results
    poll_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual event %0d quiet %0d",
                 $time, out_tdata[3:0], out_tdata[4]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[3:0] !== want.ev) begin
          $display("%0t: key_event expected %0d actual %0d",
                   $time, want.ev, out_tdata[3:0]);
          mismatches++;
        end
        if (out_tdata[4] !== want.quiet) begin
          $display("%0t: quiet_repeat expected %0d actual %0d",
                   $time, want.quiet, out_tdata[4]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule
